### sv/sarl_pkg.sv
`timescale 1ns / 1ps

package sarl_pkg;

  // Field widths fixed by the stream format.
  localparam int KEY_W    = 32;
  localparam int SYMH_W   = 16;
  localparam int STAT_W   = 3;
  localparam int ENT_W    = 9;
  localparam int IN_TD_W  = 48;
  localparam int OUT_TD_W = 64;

  // Item kinds carried in in_tuser.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Result status codes carried in out_tuser.
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXACT    = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_BELOW    = 3'd5;

endpackage

### sv/sarl_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module sarl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sorted_address_range_lookup.sv
`timescale 1ns / 1ps

// Sorted address range lookup.
// Holds up to TABLE_DEPTH (key, handle) pairs in ascending key order in one
// RAM word per entry. Input beats: in_tuser selects insert or lookup, in_tdata
// carries the key/address and the handle. Every input beat yields exactly one
// output beat with a status in out_tuser and handle, key and entry count in
// out_tdata.
// Insert: shifts larger entries up by one, one RAM read/write per cycle,
// newest-last among equal keys; at most the fill count of entries is moved.
// A full table drops it.
// Lookup: binary search for the last key <= address, one RAM probe per cycle
// (RAM read data is registered), then one read of the selected entry.
// Empty and below-all are flagged.
// One item is in the datapath at a time; the RAM read port sets the pace.
// The output register lets a new beat be accepted while a result waits; the
// next result is held until out_tready takes the previous one.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; RAM contents are not cleared, since entries past the count are
// never read.
module sorted_address_range_lookup #(
  parameter int TABLE_DEPTH = 256,
  parameter int HANDLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: addr_key[31:0], sym_handle[47:32]
  input  logic [sarl_pkg::IN_TD_W-1:0]   in_tdata,
  // in_tuser: kind[0]
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: found_handle[15:0], found_key[47:16], entries[56:48], zero pad
  output logic [sarl_pkg::OUT_TD_W-1:0]  out_tdata,
  // out_tuser: status[2:0]
  output logic [sarl_pkg::STAT_W-1:0]    out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = sarl_pkg::KEY_W + HANDLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_PUT,
    S_LK_CMP,
    S_LK_OUT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Fill count and search/shift pointers.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] mid_r, mid_nxt;

  // Latched item.
  logic [sarl_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [HANDLE_BITS-1:0]     hdl_r, hdl_nxt;

  // Staged result.
  logic [sarl_pkg::STAT_W-1:0] rs_stat_r, rs_stat_nxt;
  logic [sarl_pkg::KEY_W-1:0]  rs_key_r, rs_key_nxt;
  logic [sarl_pkg::SYMH_W-1:0] rs_hdl_r, rs_hdl_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic [sarl_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [sarl_pkg::KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [sarl_pkg::SYMH_W-1:0] out_hdl_r, out_hdl_nxt;
  logic [sarl_pkg::ENT_W-1:0]  out_ent_r, out_ent_nxt;

  // RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  logic [sarl_pkg::KEY_W-1:0] rd_key;
  logic [HANDLE_BITS-1:0]     rd_hdl;
  logic [CW-1:0]              lo_a, hi_a;
  logic                       accept;

  function automatic logic [AW-1:0] midpt(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    logic [CW-1:0] h;
    s = {1'b0, a} + {1'b0, b};
    h = s[CW:1];
    return h[AW-1:0];
  endfunction

  sarl_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(RW),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key = ram_rdata[sarl_pkg::KEY_W-1:0];
  assign rd_hdl = ram_rdata[RW-1:sarl_pkg::KEY_W];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {7'b0, out_ent_r, out_key_r, out_hdl_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hdl_nxt       = hdl_r;
    rs_stat_nxt   = rs_stat_r;
    rs_key_nxt    = rs_key_r;
    rs_hdl_nxt    = rs_hdl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_key_nxt   = out_key_r;
    out_hdl_nxt   = out_hdl_r;
    out_ent_nxt   = out_ent_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = {hdl_r, key_r};
    ram_raddr     = mid_r;
    lo_a          = lo_r;
    hi_a          = hi_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt    = in_tdata[sarl_pkg::KEY_W-1:0];
          hdl_nxt    = HANDLE_BITS'(in_tdata[sarl_pkg::IN_TD_W-1:sarl_pkg::KEY_W]);
          rs_key_nxt = '0;
          rs_hdl_nxt = '0;
          if (in_tuser == sarl_pkg::KIND_INSERT) begin
            if (cnt_r == CW'(TABLE_DEPTH)) begin
              rs_stat_nxt = sarl_pkg::ST_FULL;
              state_nxt   = S_EMIT;
            end else if (cnt_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_PUT;
            end else begin
              // Probe the current last entry first.
              pos_nxt   = cnt_r[AW-1:0];
              ram_raddr = AW'(cnt_r - CW'(1));
              state_nxt = S_INS_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              rs_stat_nxt = sarl_pkg::ST_EMPTY;
              state_nxt   = S_EMIT;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = cnt_r;
              mid_nxt   = midpt('0, cnt_r);
              ram_raddr = mid_nxt;
              state_nxt = S_LK_CMP;
            end
          end
        end
      end

      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if (rd_key > key_r) begin
          // Move the larger entry up one slot, fetch the one below it, if any.
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = S_PUT;
          end else begin
            ram_raddr = pos_r - AW'(2);
          end
        end else begin
          ram_wdata   = {hdl_r, key_r};
          cnt_nxt     = cnt_r + CW'(1);
          rs_stat_nxt = sarl_pkg::ST_INSERTED;
          state_nxt   = S_EMIT;
        end
      end

      S_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_r;
        ram_wdata   = {hdl_r, key_r};
        cnt_nxt     = cnt_r + CW'(1);
        rs_stat_nxt = sarl_pkg::ST_INSERTED;
        state_nxt   = S_EMIT;
      end

      S_LK_CMP: begin
        // Upper-bound search: lo ends as the number of keys <= address.
        if (rd_key <= key_r) begin
          lo_a = CW'(mid_r) + CW'(1);
        end else begin
          hi_a = CW'(mid_r);
        end
        lo_nxt = lo_a;
        hi_nxt = hi_a;
        if (lo_a < hi_a) begin
          mid_nxt   = midpt(lo_a, hi_a);
          ram_raddr = mid_nxt;
        end else begin
          // Below all keys selects the first entry.
          mid_nxt   = (lo_a == '0) ? '0 : AW'(lo_a - CW'(1));
          ram_raddr = mid_nxt;
          state_nxt = S_LK_OUT;
        end
      end

      S_LK_OUT: begin
        rs_key_nxt = rd_key;
        rs_hdl_nxt = sarl_pkg::SYMH_W'(rd_hdl);
        if (lo_r == '0) begin
          rs_stat_nxt = sarl_pkg::ST_BELOW;
        end else if (rd_key == key_r) begin
          rs_stat_nxt = sarl_pkg::ST_EXACT;
        end else begin
          rs_stat_nxt = sarl_pkg::ST_RANGE;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = rs_stat_r;
          out_key_nxt   = rs_key_r;
          out_hdl_nxt   = rs_hdl_r;
          out_ent_nxt   = sarl_pkg::ENT_W'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r      <= pos_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    hdl_r      <= hdl_nxt;
    rs_stat_r  <= rs_stat_nxt;
    rs_key_r   <= rs_key_nxt;
    rs_hdl_r   <= rs_hdl_nxt;
    out_stat_r <= out_stat_nxt;
    out_key_r  <= out_key_nxt;
    out_hdl_r  <= out_hdl_nxt;
    out_ent_r  <= out_ent_nxt;
  end

endmodule
